// ----- rtl/bcc_pkg.sv -----
// Shared types and constants for the button click classifier.
// Holds request, phase and event codes, per-key state and payload structs.
// No dependencies.
package bcc_pkg;

  localparam int NUM_KEYS    = 2;
  localparam int KEY_IDX_W   = (NUM_KEYS > 1) ? $clog2(NUM_KEYS) : 1;
  localparam int MAX_RESULTS = 2;
  localparam int RES_CNT_W   = $clog2(MAX_RESULTS + 1);
  localparam int RES_IDX_W   = (MAX_RESULTS > 1) ? $clog2(MAX_RESULTS) : 1;
  localparam int FIFO_DEPTH  = 4;
  localparam int FIFO_PTR_W  = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_W       = 16;
  localparam int CFG_IDX_W   = 2;

  localparam logic [3:0] MULTI_LIMIT = 4'd4;
  localparam logic [3:0] CLICK_MAX   = 4'd15;

  localparam logic [CFG_W-1:0] LONG_PRESS_RST = 16'd100;
  localparam logic [CFG_W-1:0] IDLE_GAP_RST   = 16'd30;
  localparam logic [CFG_W-1:0] TIMEOUT_RST    = 16'd200;

  localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDLE_GAP   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 2'd2;

  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_PRESS   = 2'd1,
    REQ_RELEASE = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_PRESS   = 2'd1,
    PH_RELEASE = 2'd2
  } phase_e;

  typedef enum logic [2:0] {
    EV_NONE   = 3'd0,
    EV_SHORT  = 3'd1,
    EV_DOUBLE = 3'd2,
    EV_MULTI  = 3'd3,
    EV_LONG   = 3'd4
  } ev_e;

  typedef struct packed {
    logic [CFG_W-1:0] long_press;
    logic [CFG_W-1:0] idle_gap;
    logic [CFG_W-1:0] timeout;
  } cfg_t;

  typedef struct packed {
    phase_e           phase;
    logic             check;
    logic             was_long;
    ev_e              pend;
    logic [3:0]       clicks;
    logic [CFG_W-1:0] hold;
    logic [CFG_W-1:0] idle;
    logic             flag;
  } key_state_t;

  localparam key_state_t KEY_RESET = '{
    phase:    PH_IDLE,
    check:    1'b0,
    was_long: 1'b0,
    pend:     EV_NONE,
    clicks:   4'd1,
    hold:     '0,
    idle:     TIMEOUT_RST,
    flag:     1'b0
  };

  typedef struct packed {
    logic [1:0] req_type;
    logic       key_index;
  } in_t;

  typedef struct packed {
    logic       event_key;
    logic [1:0] event_code;
    logic       last_event;
  } out_t;

endpackage

// ----- rtl/button_click_classifier_top.sv -----
// Top level of the button click classifier: config registers, per-key state, drain.
// Depends on bcc_pkg, bcc_key_lane and bcc_out_fifo.
//
// Each accepted transaction is handled in the cycle it is accepted: edges update
// the addressed key, a tick advances every key and drains up to two events in key
// order into a four-entry result queue, which registers them before the output.
// Edges can be accepted every cycle while in_ready_o is high. The queue hands out
// one result per cycle while out_ready_i is high; in_ready_o is high while there is
// room for two, so two-result ticks are throttled; otherwise one per cycle.
// Configuration writes take effect at the next cycle.
module button_click_classifier_top
  import bcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  in_t                  in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output out_t                 out_data_o
);

  cfg_t                  cfg_q;
  key_state_t            key_q [NUM_KEYS];
  key_state_t            key_d [NUM_KEYS];
  key_state_t            ticked [NUM_KEYS];
  out_t                  res [MAX_RESULTS];
  logic [RES_CNT_W-1:0]  n_res;
  logic [RES_CNT_W-1:0]  push_n;
  logic [FIFO_CNT_W-1:0] level;
  logic                  in_acc;
  logic                  key_ok;
  logic [KEY_IDX_W-1:0]  key_sel;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.long_press <= LONG_PRESS_RST;
      cfg_q.idle_gap   <= IDLE_GAP_RST;
      cfg_q.timeout    <= TIMEOUT_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_LONG_PRESS: cfg_q.long_press <= cfg_wdata_i;
        CFG_IDLE_GAP:   cfg_q.idle_gap   <= cfg_wdata_i;
        CFG_TIMEOUT:    cfg_q.timeout    <= cfg_wdata_i;
        default: begin
        end
      endcase
    end
  end

  for (genvar k = 0; k < NUM_KEYS; k++) begin : g_lane
    bcc_key_lane u_lane (
      .state_i (key_q[k]),
      .cfg_i   (cfg_q),
      .state_o (ticked[k])
    );
  end

  assign in_acc  = in_valid_i && in_ready_o;
  assign key_ok  = (32'(in_data_i.key_index) < NUM_KEYS);
  assign key_sel = KEY_IDX_W'(in_data_i.key_index);

  always_comb begin
    logic [2:0] code_w;
    code_w = '0;
    key_d  = key_q;
    n_res  = '0;
    for (int i = 0; i < MAX_RESULTS; i++) begin
      res[i] = '0;
    end
    if (in_acc) begin
      case (in_data_i.req_type)
        REQ_PRESS: begin
          if (key_ok) begin
            key_d[key_sel].check = 1'b1;
            key_d[key_sel].phase = PH_PRESS;
            key_d[key_sel].hold  = '0;
          end
        end
        REQ_RELEASE: begin
          if (key_ok) begin
            key_d[key_sel].check = 1'b1;
            key_d[key_sel].phase = PH_RELEASE;
            key_d[key_sel].idle  = '0;
          end
        end
        REQ_TICK: begin
          key_d = ticked;
          // drain raised events in key order, two at most; the rest stay raised
          for (int k = 0; k < NUM_KEYS; k++) begin
            if (key_d[k].flag && (n_res < RES_CNT_W'(MAX_RESULTS))) begin
              key_d[k].flag = 1'b0;
              if (key_d[k].pend != EV_NONE && key_d[k].pend <= EV_LONG) begin
                code_w = 3'(key_d[k].pend) - 3'd1;
                res[n_res[RES_IDX_W-1:0]].event_key  = 1'(k);
                res[n_res[RES_IDX_W-1:0]].event_code = code_w[1:0];
                n_res = n_res + RES_CNT_W'(1);
              end
              key_d[k].pend = EV_NONE;
            end
          end
          for (int i = 0; i < MAX_RESULTS; i++) begin
            res[i].last_event = (RES_CNT_W'(i + 1) == n_res);
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign push_n = n_res;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < NUM_KEYS; k++) begin
        key_q[k] <= KEY_RESET;
      end
    end else begin
      key_q <= key_d;
    end
  end

  bcc_out_fifo u_out_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_n_i    (push_n),
    .push_data_i (res),
    .pop_i       (out_ready_i),
    .head_o      (out_data_o),
    .not_empty_o (out_valid_o),
    .level_o     (level)
  );

  assign in_ready_o = (level <= FIFO_CNT_W'(FIFO_DEPTH - MAX_RESULTS));

`ifndef SYNTHESIS
  a_edge_no_result : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_acc && in_data_i.req_type != REQ_TICK && !out_valid_o) |=> !out_valid_o)
    else $error("edge transaction produced a result");

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    level <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue overflow");

  a_clicks_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    key_q[0].clicks != 4'd0)
    else $error("click count reached zero");
`endif

endmodule

// ----- rtl/bcc_key_lane.sv -----
// Tick advance for one key: hold and idle counting, click grouping, event raising.
// Combinational; depends on bcc_pkg.
module bcc_key_lane
  import bcc_pkg::*;
(
  input  key_state_t state_i,
  input  cfg_t       cfg_i,
  output key_state_t state_o
);

  key_state_t s;

  always_comb begin
    s = state_i;
    case (state_i.phase)
      PH_PRESS: begin
        if (s.hold < cfg_i.timeout) begin
          s.hold = s.hold + 16'd1;
        end
        if (s.hold > cfg_i.long_press) begin
          if (s.pend != EV_NONE) begin
            // long hold with an event waiting: flush that event first
            if (s.clicks > 4'd1) begin
              s.clicks = s.clicks - 4'd1;
            end
            s.flag = 1'b1;
          end else begin
            s.was_long = 1'b1;
            s.phase    = PH_IDLE;
            s.pend     = EV_LONG;
            s.flag     = 1'b1;
            s.clicks   = 4'd1;
            s.idle     = cfg_i.timeout;
          end
        end
        if (s.check) begin
          s.check = 1'b0;
          if (!s.was_long) begin
            if (s.idle < cfg_i.idle_gap) begin
              if (s.clicks < CLICK_MAX) begin
                s.clicks = s.clicks + 4'd1;
              end
            end else begin
              s.clicks = 4'd1;
            end
          end
          s.was_long = 1'b0;
        end
      end
      PH_RELEASE: begin
        if (s.idle < cfg_i.timeout) begin
          s.idle = s.idle + 16'd1;
        end
        if (s.check) begin
          s.check = 1'b0;
          if (!s.was_long) begin
            if (s.clicks > 4'd1) begin
              s.pend = (s.clicks > MULTI_LIMIT) ? EV_MULTI : EV_DOUBLE;
            end else begin
              s.pend   = EV_SHORT;
              s.clicks = 4'd1;
            end
          end
        end
        // sequence over: raise the event and drop back to idle
        if (s.idle > cfg_i.idle_gap && !s.was_long) begin
          s.flag  = 1'b1;
          s.phase = PH_IDLE;
        end
      end
      default: begin
      end
    endcase
  end

  assign state_o = s;

endmodule

// ----- rtl/bcc_out_fifo.sv -----
// Result queue: takes up to MAX_RESULTS entries per cycle, hands out one.
// Depends on bcc_pkg.
module bcc_out_fifo
  import bcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic [RES_CNT_W-1:0] push_n_i,
  input  out_t                 push_data_i [MAX_RESULTS],
  input  logic                 pop_i,
  output out_t                 head_o,
  output logic                 not_empty_o,
  output logic [FIFO_CNT_W-1:0] level_o
);

  out_t                  mem_q [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [FIFO_PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [FIFO_CNT_W-1:0] cnt_q, cnt_d;
  logic                  pop;

  assign pop = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q + FIFO_PTR_W'(push_n_i);
    rd_ptr_d = rd_ptr_q + FIFO_PTR_W'(pop);
    cnt_d    = cnt_q + FIFO_CNT_W'(push_n_i) - FIFO_CNT_W'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < MAX_RESULTS; i++) begin
      if (RES_CNT_W'(i) < push_n_i) begin
        mem_q[wr_ptr_q + FIFO_PTR_W'(i)] <= push_data_i[i];
      end
    end
  end

  assign head_o      = mem_q[rd_ptr_q];
  assign not_empty_o = (cnt_q != '0);
  assign level_o     = cnt_q;

endmodule

// ----- tb/sv/bcc_event_checker.sv -----
// Checker for the button click classifier: follows every transaction on both channels.
// It predicts the click events from its own copy of the key state and registers.
// Depends on bcc_pkg.
module bcc_event_checker
  import bcc_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  input  logic                 in_ready_i,
  input  in_t                  in_data_i,
  input  logic                 out_valid_i,
  input  logic                 out_ready_i,
  input  out_t                 out_data_i,
  output int                   fail_count_o,
  output int                   open_count_o
);

  cfg_t       cfg_q;
  key_state_t keys [NUM_KEYS];
  out_t       expected_events [$];
  int         mismatches = 0;

  assign fail_count_o = mismatches;

  task automatic report(string msg);
    $display("[%0t] mismatch: %s", $time, msg);
    mismatches++;
  endtask

  function automatic key_state_t advance_held(key_state_t s);
    if (s.hold < cfg_q.timeout) s.hold = s.hold + 1'b1;
    if (s.hold > cfg_q.long_press) begin
      if (s.pend != EV_NONE) begin
        // long hold with an event still pending: release that one first
        if (s.clicks > 4'd1) s.clicks = s.clicks - 1'b1;
        s.flag = 1'b1;
      end else begin
        s.was_long = 1'b1;
        s.phase    = PH_IDLE;
        s.pend     = EV_LONG;
        s.flag     = 1'b1;
        s.clicks   = 4'd1;
        s.idle     = cfg_q.timeout;
      end
    end
    if (s.check) begin
      s.check = 1'b0;
      if (!s.was_long) begin
        if (s.idle < cfg_q.idle_gap) begin
          if (s.clicks < CLICK_MAX) s.clicks = s.clicks + 1'b1;
        end else begin
          s.clicks = 4'd1;
        end
      end
      s.was_long = 1'b0;
    end
    return s;
  endfunction

  function automatic key_state_t advance_released(key_state_t s);
    if (s.idle < cfg_q.timeout) s.idle = s.idle + 1'b1;
    if (s.check) begin
      s.check = 1'b0;
      if (!s.was_long) begin
        if (s.clicks > 4'd1) begin
          s.pend = (s.clicks > MULTI_LIMIT) ? EV_MULTI : EV_DOUBLE;
        end else begin
          s.pend   = EV_SHORT;
          s.clicks = 4'd1;
        end
      end
    end
    if (s.idle > cfg_q.idle_gap && !s.was_long) begin
      s.flag  = 1'b1;
      s.phase = PH_IDLE;
    end
    return s;
  endfunction

  // Advance every key, then drain flagged events in key order, two at most.
  task automatic predict_tick();
    out_t evs [MAX_RESULTS];
    int   n;
    n = 0;
    for (int k = 0; k < NUM_KEYS; k++) begin
      case (keys[k].phase)
        PH_PRESS:   keys[k] = advance_held(keys[k]);
        PH_RELEASE: keys[k] = advance_released(keys[k]);
        default: ;
      endcase
    end
    for (int k = 0; k < NUM_KEYS && n < MAX_RESULTS; k++) begin
      if (keys[k].flag) begin
        keys[k].flag = 1'b0;
        if (keys[k].pend != EV_NONE) begin
          evs[n].event_key  = 1'(k);
          evs[n].event_code = 2'(keys[k].pend - EV_SHORT);
          evs[n].last_event = 1'b0;
          n++;
        end
        keys[k].pend = EV_NONE;
      end
    end
    if (n > 0) evs[n-1].last_event = 1'b1;
    for (int i = 0; i < n; i++) expected_events.push_back(evs[i]);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    out_t want;
    int   k;
    if (!rst_ni) begin
      cfg_q = '{long_press: LONG_PRESS_RST, idle_gap: IDLE_GAP_RST, timeout: TIMEOUT_RST};
      for (int i = 0; i < NUM_KEYS; i++) keys[i] = KEY_RESET;
      expected_events.delete();
    end else begin
      if (in_valid_i && in_ready_i) begin
        k = int'(in_data_i.key_index);
        case (in_data_i.req_type)
          REQ_TICK: predict_tick();
          REQ_PRESS: begin
            if (k < NUM_KEYS) begin
              keys[k].check = 1'b1;
              keys[k].phase = PH_PRESS;
              keys[k].hold  = '0;
            end
          end
          REQ_RELEASE: begin
            if (k < NUM_KEYS) begin
              keys[k].check = 1'b1;
              keys[k].phase = PH_RELEASE;
              keys[k].idle  = '0;
            end
          end
          default: ;  // unused request code: drop
        endcase
      end

      if (out_valid_i && out_ready_i) begin
        if (expected_events.size() == 0) begin
          report($sformatf("event key %0d code %0d with none expected",
                           out_data_i.event_key, out_data_i.event_code));
        end else begin
          want = expected_events.pop_front();
          if (out_data_i.event_key != want.event_key)
            report($sformatf("event_key got %0d want %0d",
                             out_data_i.event_key, want.event_key));
          if (out_data_i.event_code != want.event_code)
            report($sformatf("event_code got %0d want %0d",
                             out_data_i.event_code, want.event_code));
          if (out_data_i.last_event != want.last_event)
            report($sformatf("last_event got %0d want %0d",
                             out_data_i.last_event, want.last_event));
        end
      end

      // writes land after any transaction of the same edge
      if (cfg_we_i) begin
        case (cfg_index_i)
          CFG_LONG_PRESS: cfg_q.long_press = cfg_wdata_i;
          CFG_IDLE_GAP:   cfg_q.idle_gap   = cfg_wdata_i;
          CFG_TIMEOUT:    cfg_q.timeout    = cfg_wdata_i;
          default: ;
        endcase
      end
    end
    open_count_o = expected_events.size();
  end

endmodule

// ----- tb/sv/tb_button_click_classifier_top.sv -----
// Testbench top for button_click_classifier_top: clock, reset, register setup and stimulus.
// Drives directed and random click sequences under random stalls; bcc_event_checker checks.
// Depends on bcc_pkg, button_click_classifier_top and bcc_event_checker.
module tb_button_click_classifier_top;
  import bcc_pkg::*;

  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam logic [1:0]           REQ_SPARE = 2'd3;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int MAX_WAIT     = 18;
  localparam int STALL_CYCLES = 300;
  localparam int SETTLE       = 6;
  localparam int TICK_CAP     = 30;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_index_i;
  logic [CFG_W-1:0]     cfg_wdata_i;
  logic                 in_valid_i;
  logic                 in_ready_o;
  in_t                  in_data_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  out_t                 out_data_o;

  int mismatch_cnt;
  int open_cnt;
  int items_sent;
  int cycles;
  int cur_lp;
  int cur_ig;
  bit sender_quiet;
  bit stall_req;
  bit stall_done;

  button_click_classifier_top dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  bcc_event_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_ready_i   (in_ready_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .out_data_i   (out_data_o),
    .fail_count_o (mismatch_cnt),
    .open_count_o (open_cnt)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    cycles = 0;
    while (cycles <= CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("timeout after %0d cycles, %0d events outstanding", cycles, open_cnt);
    $display("*** FAILED ***");
    $finish;
  end

  // Offer one transaction after a random gap and hold it until accepted.
  task automatic send_req(logic [1:0] req, logic key);
    in_t item;
    int  gap;
    item.req_type  = req;
    item.key_index = key;
    gap = sender_quiet ? 0 : $urandom_range(0, MAX_WAIT);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    if (req != REQ_SPARE) items_sent++;
  endtask

  task automatic ticks(int n);
    repeat (n) send_req(REQ_TICK, 1'($urandom_range(0, 1)));
  endtask

  task automatic key_down(logic k);
    send_req(REQ_PRESS, k);
  endtask

  task automatic key_up(logic k);
    send_req(REQ_RELEASE, k);
  endtask

  // Drop valid and let all outstanding events drain before touching registers.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (open_cnt != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic set_config(logic [CFG_W-1:0] lp, logic [CFG_W-1:0] ig,
                            logic [CFG_W-1:0] to);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= CFG_LONG_PRESS;
    cfg_wdata_i <= lp;
    @(posedge clk_i);
    cfg_index_i <= CFG_IDLE_GAP;
    cfg_wdata_i <= ig;
    @(posedge clk_i);
    cfg_index_i <= CFG_TIMEOUT;
    cfg_wdata_i <= to;
    @(posedge clk_i);
    // unused index: must leave every register alone
    cfg_index_i <= CFG_SPARE;
    cfg_wdata_i <= 16'($urandom);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    cur_lp = (lp > TICK_CAP) ? TICK_CAP : int'(lp);
    cur_ig = (ig > TICK_CAP) ? TICK_CAP : int'(ig);
  endtask

  task automatic click_burst();
    int k;
    int clicks;
    k = $urandom_range(0, NUM_KEYS - 1);
    clicks = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 17) : $urandom_range(1, 4);
    repeat (clicks) begin
      key_down(1'(k));
      ticks(($urandom_range(0, 5) == 0) ? cur_lp + $urandom_range(1, 3)
                                        : $urandom_range(0, cur_lp));
      // stray edge from the other key
      if ($urandom_range(0, 5) == 0) send_req(2'($urandom_range(1, 2)), 1'(1 - k));
      key_up(1'(k));
      ticks($urandom_range(0, cur_ig + 1));
    end
    ticks(cur_ig + 2);
  endtask

  // Same click on both keys so that two events drain in one tick.
  task automatic paired_clicks();
    key_down(1'b0);
    key_down(1'b1);
    ticks($urandom_range(1, cur_lp));
    key_up(1'b0);
    key_up(1'b1);
    ticks(cur_ig + 2);
  endtask

  task automatic long_hold();
    int k;
    k = $urandom_range(0, NUM_KEYS - 1);
    key_down(1'(k));
    ticks(cur_lp + $urandom_range(1, 4));
    key_up(1'(k));
    ticks(cur_ig + 2);
  endtask

  task automatic run_random(int count);
    int stop_at;
    int pick;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      sender_quiet = ($urandom_range(0, 3) == 0);
      pick = $urandom_range(0, 19);
      if (pick < 11)
        click_burst();
      else if (pick < 14)
        paired_clicks();
      else if (pick < 17)
        long_hold();
      else
        repeat ($urandom_range(1, 6))
          send_req(2'($urandom_range(0, 3)), 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: random hold-offs, zero-wait stretches, one long stall on request.
  initial begin
    int gap;
    int served;
    served      = 0;
    stall_done  = 1'b0;
    out_ready_i <= 1'b0;
    wait (rst_ni === 1'b1);
    forever begin
      if (stall_req && !stall_done) begin
        out_ready_i <= 1'b0;
        repeat (STALL_CYCLES) @(posedge clk_i);
        stall_done = 1'b1;
      end
      gap = (served % 64 < 16) ? 0 : $urandom_range(0, MAX_WAIT);
      if (gap > 0) begin
        out_ready_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      do @(posedge clk_i); while (!out_valid_o);
      served++;
    end
  end

  initial begin
    rst_ni       <= 1'b0;
    cfg_we_i     <= 1'b0;
    cfg_index_i  <= CFG_LONG_PRESS;
    cfg_wdata_i  <= '0;
    in_valid_i   <= 1'b0;
    in_data_i    <= '0;
    items_sent   = 0;
    sender_quiet = 1'b0;
    stall_req    = 1'b0;
    cur_lp       = TICK_CAP;
    cur_ig       = TICK_CAP;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset register values
    run_random(30);

    wait_idle();
    set_config(16'd4, 16'd3, 16'd12);
    // unused request code: ignored
    send_req(REQ_SPARE, 1'b1);
    // double click on key 0 while key 1 is held into a long press
    key_down(1'b0);
    key_down(1'b1);
    ticks(1);
    key_up(1'b0);
    ticks(1);
    key_down(1'b0);
    ticks(1);
    key_up(1'b0);
    ticks(4);
    // long hold while a short click is pending: the short one goes out first
    key_down(1'b0);
    ticks(1);
    key_up(1'b0);
    ticks(1);
    key_down(1'b0);
    ticks(6);
    key_up(1'b0);
    ticks(1);

    // receiver stalls while both keys keep producing events
    stall_req    = 1'b1;
    sender_quiet = 1'b1;
    repeat (12) paired_clicks();
    sender_quiet = 1'b0;
    run_random(50);

    wait_idle();
    set_config(16'd1, 16'd1, 16'd1);
    run_random(50);

    wait_idle();
    set_config(16'd0, 16'd0, 16'd0);
    run_random(50);

    wait_idle();
    set_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
    run_random(20);

    wait_idle();
    set_config(16'hFFFF, 16'd3, 16'hFFFF);
    run_random(40);

    // timeout below the long-press threshold: holds never turn long
    wait_idle();
    set_config(16'd6, 16'd2, 16'd5);
    run_random(50);

    repeat (2) begin
      wait_idle();
      set_config(16'($urandom_range(1, 12)), 16'($urandom_range(1, 8)),
                 16'($urandom_range(1, 16)));
      run_random(50);
    end

    wait_idle();
    if (mismatch_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/bcc_pkg.sv
rtl/bcc_key_lane.sv
rtl/bcc_out_fifo.sv
rtl/button_click_classifier_top.sv
tb/sv/bcc_event_checker.sv
tb/sv/tb_button_click_classifier_top.sv
